/* rtl/core/crcfx_pkg.sv */
package crcfx_pkg;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // marker + second byte + length byte + two CRC bytes
    localparam logic [8:0] FRAME_OVERHEAD = 9'd5;
    localparam logic [8:0] LEN_BYTE_IDX   = 9'd2;

    localparam logic [0:0] REG_START_MARKER = 1'b0;
    localparam logic [7:0] START_MARKER_RST = 8'hAA;

    typedef enum logic [1:0] {
        KIND_CRC  = 2'd0,   // byte goes through the CRC
        KIND_LOW  = 2'd1,   // received CRC, low byte
        KIND_LAST = 2'd2    // received CRC, high byte, closes the frame
    } byte_kind_t;

    typedef struct packed {
        logic [7:0] data;
        logic [8:0] idx;
        logic [8:0] total_len;
        byte_kind_t kind;
    } fifo_entry_t;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

/* rtl/core/crcfx_front.sv */
module crcfx_front
    import crcfx_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [7:0]  start_marker,
    input  logic        in_xfer,
    input  logic [7:0]  in_byte,
    output logic        push,
    output fifo_entry_t push_entry
);

    logic       in_frame_reg, in_frame_next;
    logic [8:0] byte_count_reg, byte_count_next;
    logic [8:0] total_len_reg, total_len_next;

    logic       take;
    logic [8:0] idx;
    logic [8:0] tl;
    logic [9:0] idx_p2;
    byte_kind_t kind;

    assign take   = in_frame_reg || (in_byte == start_marker);
    assign idx    = in_frame_reg ? byte_count_reg : 9'd0;
    assign idx_p2 = {1'b0, idx} + 10'd2;

    always_comb begin
        if (idx == LEN_BYTE_IDX) begin
            tl = FRAME_OVERHEAD + {1'b0, in_byte};
        end else if (in_frame_reg) begin
            tl = total_len_reg;
        end else begin
            tl = 9'd0;
        end

        if (tl == 9'd0 || idx_p2 < {1'b0, tl}) begin
            kind = KIND_CRC;
        end else if (idx_p2 == {1'b0, tl}) begin
            kind = KIND_LOW;
        end else begin
            kind = KIND_LAST;
        end
    end

    assign push                 = in_xfer && take;
    assign push_entry.data      = in_byte;
    assign push_entry.idx       = idx;
    assign push_entry.total_len = tl;
    assign push_entry.kind      = kind;

    always_comb begin
        in_frame_next   = in_frame_reg;
        byte_count_next = byte_count_reg;
        total_len_next  = total_len_reg;
        if (push) begin
            if (kind == KIND_LAST) begin
                in_frame_next   = 1'b0;
                byte_count_next = 9'd0;
                total_len_next  = 9'd0;
            end else begin
                in_frame_next   = 1'b1;
                byte_count_next = idx + 9'd1;
                total_len_next  = tl;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_frame_reg   <= 1'b0;
            byte_count_reg <= 9'd0;
            total_len_reg  <= 9'd0;
        end else begin
            in_frame_reg   <= in_frame_next;
            byte_count_reg <= byte_count_next;
            total_len_reg  <= total_len_next;
        end
    end

    a_hunt_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_frame_reg |-> (byte_count_reg == 9'd0 && total_len_reg == 9'd0))
        else $error("hunting with stale frame counters");

    a_len_known: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_frame_reg && byte_count_reg > LEN_BYTE_IDX) |-> total_len_reg >= FRAME_OVERHEAD)
        else $error("frame past length byte without a length");

endmodule

/* rtl/core/crcfx_fifo.sv */
module crcfx_fifo
    import crcfx_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push,
    input  fifo_entry_t push_entry,
    input  logic        pop,
    output fifo_entry_t head,
    output logic        full,
    output logic        empty
);

    fifo_entry_t mem_reg [FIFO_DEPTH];

    logic [FIFO_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_AW:0]   count_reg, count_next;

    assign full  = (count_reg == (FIFO_AW+1)'(FIFO_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        full |-> !push)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        empty |-> !pop)
        else $error("pop from empty queue");

endmodule

/* rtl/core/crcfx_back.sv */
module crcfx_back
    import crcfx_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        q_empty,
    input  fifo_entry_t q_head,
    output logic        pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,
    output logic        m_tlast,
    output logic        m_tuser
);

    logic [15:0] crc_reg, crc_next;
    logic [7:0]  rx_low_reg, rx_low_next;
    logic        valid_reg, valid_next;
    logic [7:0]  byte_reg;
    logic [8:0]  idx_reg;
    logic [8:0]  len_reg;
    logic        last_reg;
    logic        ok_reg;
    logic        is_last;
    logic        ok;

    assign pop     = !q_empty && (!valid_reg || m_tready);
    assign is_last = (q_head.kind == KIND_LAST);
    assign ok      = is_last && ({q_head.data, rx_low_reg} == crc_reg);

    always_comb begin
        crc_next    = crc_reg;
        rx_low_next = rx_low_reg;
        valid_next  = valid_reg;
        if (m_tready) begin
            valid_next = 1'b0;
        end
        if (pop) begin
            valid_next = 1'b1;
            case (q_head.kind)
                KIND_CRC:  crc_next = crc16_byte(crc_reg, q_head.data);
                KIND_LOW:  rx_low_next = q_head.data;
                KIND_LAST: begin
                    crc_next    = CRC_INIT;
                    rx_low_next = 8'h00;
                end
                default:   crc_next = crc_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg    <= CRC_INIT;
            rx_low_reg <= 8'h00;
            valid_reg  <= 1'b0;
        end else begin
            crc_reg    <= crc_next;
            rx_low_reg <= rx_low_next;
            valid_reg  <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            byte_reg <= q_head.data;
            idx_reg  <= q_head.idx;
            len_reg  <= q_head.total_len;
            last_reg <= is_last;
            ok_reg   <= ok;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {6'd0, len_reg, idx_reg, byte_reg};
    assign m_tlast  = last_reg;
    assign m_tuser  = ok_reg;

    a_ok_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && ok_reg) |-> last_reg)
        else $error("crc_ok outside the final byte");

    a_last_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && last_reg) |-> (len_reg == idx_reg + 9'd1))
        else $error("last byte index does not match frame length");

endmodule

/* rtl/core/crc16_checked_frame_extractor.sv */
// Checked frame receiver, CRC-16 Modbus style (poly 0xA001, init 0xFFFF).
// Input stream s_*: one received byte per transfer. While hunting, bytes are
// dropped until one equals start_marker; that byte is index 0, byte 2 holds
// the payload length L, and the frame runs 3 + L + 2 bytes.
// Output stream m_*: one transfer per frame byte with its index and the
// frame length (0 until the length byte is seen). tlast marks the final CRC
// byte, tuser on it is 1 when the received little-endian CRC matches.
// APB port: register 0 (address 0) is start_marker, reset 0xAA.
// Throughput: one byte per cycle, sustained while m_tready stays high. A byte
// passes from s_* through the combinational front classifier into a
// 4-entry queue, then through the CRC back end into the output register.
// When m_tready stays low the queue fills and s_tready drops after four
// more bytes; nothing is lost. s_tready may also drop briefly while the
// queue is full even for bytes that would be dropped while hunting.
// Reset (aresetn low, synchronous) clears the queue and output valid,
// returns to hunting and restores the marker and CRC state.
module crc16_checked_frame_extractor
    import crcfx_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // [7:0] frame_byte, [16:8] byte_index,
                                    // [25:17] frame_length, [31:26] zero
    output logic        m_tlast,    // last_byte
    output logic        m_tuser,    // crc_ok
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [7:0]  marker_reg, marker_next;
    logic        reg_hit;
    logic        in_xfer;
    logic        push;
    logic        pop;
    logic        q_full;
    logic        q_empty;
    fifo_entry_t push_entry;
    fifo_entry_t q_head;

    assign pready  = 1'b1;
    assign reg_hit = (paddr[2] == REG_START_MARKER);
    assign prdata  = reg_hit ? {24'd0, marker_reg} : 32'd0;

    always_comb begin
        marker_next = marker_reg;
        if (psel && penable && pwrite && pready && reg_hit && paddr[1:0] == 2'b00) begin
            marker_next = pwdata[7:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            marker_reg <= START_MARKER_RST;
        end else begin
            marker_reg <= marker_next;
        end
    end

    assign s_tready = !q_full;
    assign in_xfer  = s_tvalid && s_tready;

    crcfx_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .start_marker (marker_reg),
        .in_xfer      (in_xfer),
        .in_byte      (s_tdata),
        .push         (push),
        .push_entry   (push_entry)
    );

    crcfx_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (q_head),
        .full       (q_full),
        .empty      (q_empty)
    );

    crcfx_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .q_head   (q_head),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

/* test/crc16_checked_frame_extractor_test.sv */
module crc16_checked_frame_extractor_test;
    import crcfx_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [7:0] frame_byte;
        logic [8:0] byte_index;
        logic       last_byte;
        logic [8:0] frame_length;
        logic       crc_ok;
    } frame_out_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;      // [7:0] rx_byte
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;              // [7:0] frame_byte, [16:8] byte_index,
                                       // [25:17] frame_length, [31:26] zero
    logic        m_tlast;
    logic        m_tuser;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    crc16_checked_frame_extractor dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // receiver-side frame tracker
    logic [7:0]  trk_marker = START_MARKER_RST;
    logic        trk_in_frame = 1'b0;
    logic [8:0]  trk_count = '0;
    logic [8:0]  trk_total = '0;
    logic [15:0] trk_crc = CRC_INIT;
    logic [7:0]  trk_crc_lo = '0;

    logic [7:0]  rx_bytes_q[$];
    frame_out_t  frame_out_q[$];
    logic [7:0]  frame_body[$];        // second byte, then payload

    int gap_mode = 0;
    int stall_mode = 0;
    int gap_left = 0;
    int stall_left = 0;
    int bytes_queued = 0;
    int bytes_sent = 0;
    int outs_checked = 0;
    int frames_good = 0;
    int frames_bad = 0;
    int fail_count = 0;
    frame_out_t want;

    function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
        end
        return c;
    endfunction

    // mostly short pauses, now and then a long one; mode 0 never pauses
    function automatic int pick_pause(input int mode);
        int r;
        r = $urandom_range(0, 99);
        if (mode == 0) return 0;
        if (mode == 1) begin
            if (r < 75) return 0;
            if (r < 95) return $urandom_range(1, 3);
            return $urandom_range(8, 40);
        end
        if (r < 40) return 0;
        if (r < 85) return $urandom_range(1, 4);
        return $urandom_range(10, 60);
    endfunction

    task automatic track_rx_byte(input logic [7:0] b);
        frame_out_t o;
        if (!trk_in_frame) begin
            if (b != trk_marker) return;
            trk_in_frame = 1'b1;
            trk_count    = '0;
            trk_total    = '0;
            trk_crc      = CRC_INIT;
            trk_crc_lo   = '0;
        end
        o.frame_byte = b;
        o.byte_index = trk_count;
        o.last_byte  = 1'b0;
        o.crc_ok     = 1'b0;
        if (trk_count == LEN_BYTE_IDX) trk_total = FRAME_OVERHEAD + 9'(b);
        if (trk_total == 0 || trk_count + 9'd2 < trk_total) begin
            trk_crc = crc16_step(trk_crc, b);
        end else if (trk_count + 9'd2 == trk_total) begin
            trk_crc_lo = b;
        end else begin
            o.last_byte = 1'b1;
            o.crc_ok    = ({b, trk_crc_lo} == trk_crc);
        end
        o.frame_length = trk_total;
        frame_out_q.push_back(o);
        if (o.last_byte) begin
            trk_in_frame = 1'b0;
            trk_count    = '0;
            trk_total    = '0;
            trk_crc      = CRC_INIT;
            trk_crc_lo   = '0;
        end else begin
            trk_count = trk_count + 9'd1;
        end
    endtask

    task automatic check_field(input string name, input int unsigned exp_v,
                               input int unsigned act_v);
        if (exp_v != act_v) begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    // sender
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                track_rx_byte(s_tdata);
                bytes_sent++;
            end
            if (!(s_tvalid && !s_tready)) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (rx_bytes_q.size() > 0) begin
                    s_tdata  <= rx_bytes_q.pop_front();
                    s_tvalid <= 1'b1;
                    gap_left = pick_pause(gap_mode);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver backpressure
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            stall_left = pick_pause(stall_mode);
        end
    end

    // result checker
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (frame_out_q.size() == 0) begin
                $error("unexpected transfer: frame_byte %0d, byte_index %0d",
                       m_tdata[7:0], m_tdata[16:8]);
                fail_count++;
            end else begin
                want = frame_out_q.pop_front();
                check_field("frame_byte", want.frame_byte, m_tdata[7:0]);
                check_field("byte_index", want.byte_index, m_tdata[16:8]);
                check_field("frame_length", want.frame_length, m_tdata[25:17]);
                check_field("last_byte", want.last_byte, m_tlast);
                check_field("crc_ok", want.crc_ok, m_tuser);
                outs_checked++;
            end
            if (m_tlast) begin
                if (m_tuser) frames_good++;
                else frames_bad++;
            end
        end
    end

    task automatic put_byte(input logic [7:0] b);
        rx_bytes_q.push_back(b);
        bytes_queued++;
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        trk_marker = data[7:0];
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic drain;
        do @(posedge aclk);
        while (rx_bytes_q.size() != 0 || s_tvalid || frame_out_q.size() != 0);
        // leave some margin for bytes still inside the block
        repeat (6) @(posedge aclk);
    endtask

    // feed filler until a frame left open by a truncated sequence has ended
    task automatic close_open_frame;
        while (trk_in_frame) begin
            put_byte(8'($urandom_range(0, 255)));
            drain();
        end
    endtask

    task automatic rand_body(input int len);
        int r;
        frame_body.delete();
        for (int i = 0; i <= len; i++) begin
            r = $urandom_range(0, 99);
            if (r < 10) frame_body.push_back(trk_marker);
            else if (r < 15) frame_body.push_back(8'h00);
            else if (r < 20) frame_body.push_back(8'hFF);
            else frame_body.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    // keep == 0 sends the whole frame, otherwise only the first keep bytes
    task automatic queue_frame(input bit bad_crc, input int keep);
        logic [7:0]  bytes[$];
        logic [15:0] crc;
        bytes.push_back(trk_marker);
        bytes.push_back(frame_body[0]);
        bytes.push_back(8'(frame_body.size() - 1));
        for (int i = 1; i < frame_body.size(); i++) bytes.push_back(frame_body[i]);
        crc = CRC_INIT;
        foreach (bytes[i]) crc = crc16_step(crc, bytes[i]);
        if (bad_crc) crc = crc ^ 16'($urandom_range(1, 16'hFFFF));
        bytes.push_back(crc[7:0]);
        bytes.push_back(crc[15:8]);
        if (keep == 0) keep = bytes.size();
        for (int i = 0; i < keep; i++) put_byte(bytes[i]);
    endtask

    task automatic queue_noise(input int n);
        logic [7:0] b;
        for (int i = 0; i < n; i++) begin
            do b = 8'($urandom_range(0, 255)); while (b == trk_marker);
            put_byte(b);
        end
    endtask

    function automatic int pick_len;
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(0, 6);
        if (r < 96) return $urandom_range(7, 40);
        return $urandom_range(41, 255);
    endfunction

    initial begin
        logic [7:0] marker_set[5];
        int gap_set[5];
        int stall_set[5];
        int r;
        int len;
        int phase_end;

        marker_set = '{START_MARKER_RST, 8'h00, 8'hFF, 8'h00, 8'h5A};
        marker_set[3] = 8'($urandom_range(1, 254));
        gap_set   = '{0, 1, 0, 1, 2};
        stall_set = '{0, 1, 2, 0, 2};

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: stray bytes, shortest frames with good and bad CRC,
        // marker value inside a frame
        put_byte(8'h00);
        put_byte(8'hFF);
        put_byte(8'h55);
        frame_body.delete();
        frame_body.push_back(8'h00);
        queue_frame(1'b0, 0);
        frame_body.delete();
        frame_body.push_back(8'hFF);
        queue_frame(1'b1, 0);
        frame_body = '{START_MARKER_RST, START_MARKER_RST, 8'h00, 8'hFF};
        queue_frame(1'b0, 0);
        drain();

        for (int p = 1; p < 5; p++) begin
            gap_mode   = gap_set[p];
            stall_mode = stall_set[p];
            apb_write(3'(4 * int'(REG_START_MARKER)), {24'd0, marker_set[p]});
            phase_end = bytes_queued + 345;
            if (p == 1) begin
                // longest frame: index 259, length 260
                rand_body(255);
                queue_frame(1'b0, 0);
            end
            while (bytes_queued < phase_end) begin
                r = $urandom_range(0, 99);
                if (r < 18) begin
                    queue_noise($urandom_range(1, 4));
                end else begin
                    len = pick_len();
                    rand_body(len);
                    if (r < 23) queue_frame(1'b0, $urandom_range(1, len + 4));
                    else queue_frame(r < 32, 0);
                end
            end
            drain();
            close_open_frame();
        end

        repeat (20) @(posedge aclk);
        $display("sent %0d bytes, checked %0d frame bytes over 5 marker settings",
                 bytes_sent, outs_checked);
        $display("frames closed: %0d with CRC match, %0d with CRC mismatch",
                 frames_good, frames_bad);
        if (fail_count == 0 && frame_out_q.size() == 0) begin
            $display("tb: success");
        end else begin
            if (frame_out_q.size() != 0)
                $error("%0d expected transfers never arrived", frame_out_q.size());
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("timeout waiting for the run to finish");
        $display("tb: failure");
        $finish;
    end

endmodule
